### rtl/itf_pkg.sv
// Package for int_to_float_convert: format codes and field widths.
// No dependencies.
`default_nettype none
package itf_pkg;
    localparam int DataW = 64;
    localparam logic KIND_DOUBLE = 1'b0;
    localparam logic KIND_SINGLE = 1'b1;
    typedef logic [DataW-1:0] word_t;
    typedef logic [6:0] lzc_t;
endpackage
`default_nettype wire

### rtl/int_to_float_convert.sv
// int_to_float_convert: signed integer to IEEE 754 double/single, round to nearest even.
// Depends on itf_pkg.
//
// Usage:
//   Input channel s_valid/s_ready carries one item: s_kind (0 double, 1 single),
//   s_source_is_64 (1 = 64-bit signed source, else low 32 bits signed) and s_value.
//   Result channel m_valid/m_ready carries m_result_bits; a single result sits
//   in bits 31..0 with the upper half zero.
//   Stage 1 registers sign and magnitude, stage 2 does leading-zero count,
//   normalize, round and pack into the output register.
//   Throughput: one item per cycle; each stage advances when the stage after
//   it is empty or being drained.
//   Reset: synchronous, active-low aresetn empties both stages.
//   Stall: while m_ready is low the result holds and the stages fill; s_ready
//   drops once both are occupied.
`default_nettype none
module int_to_float_convert
    import itf_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_kind,
    input  wire logic        s_source_is_64,
    input  wire logic [63:0] s_value,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_result_bits
);
    logic  v1_reg, v2_reg;
    logic  kind_reg, neg_reg;
    word_t mag_reg, res_reg;
    logic  adv1, adv2;
    word_t sx, mag_next, norm, res_next, dbl, sgl;
    lzc_t  lz;
    logic  neg_next;

    assign adv2    = v1_reg && (!v2_reg || m_ready);
    assign s_ready = !v1_reg || adv2;
    assign adv1    = s_valid && s_ready;

    always_comb begin
        sx = s_source_is_64 ? s_value : {{32{s_value[31]}}, s_value[31:0]};
        neg_next = sx[63];
        mag_next = neg_next ? (~sx + 64'd1) : sx;
    end

    always_comb begin
        lz = 7'd64;
        for (int i = 0; i < 64; i++) begin
            if (mag_reg[i]) lz = 7'(63 - i);
        end
    end

    always_comb begin
        logic [53:0] md;
        logic [24:0] ms;
        logic [10:0] ed;
        logic [7:0]  es;
        logic        rd, rs;
        norm = mag_reg << lz[5:0];
        rd = norm[10] && (norm[9:0] != '0 || norm[11]);
        md = {1'b0, norm[63:11]} + 54'(rd);
        ed = 11'd1086 - 11'(lz) + 11'(md[53]);
        dbl = {neg_reg, ed, md[53] ? 52'd0 : md[51:0]};
        rs = norm[39] && (norm[38:0] != '0 || norm[40]);
        ms = {1'b0, norm[63:40]} + 25'(rs);
        es = 8'd190 - 8'(lz) + 8'(ms[24]);
        sgl = {32'd0, neg_reg, es, ms[24] ? 23'd0 : ms[22:0]};
        if (lz[6]) res_next = '0;
        else if (kind_reg == KIND_SINGLE) res_next = sgl;
        else res_next = dbl;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= 1'b1;
            else if (adv2) v1_reg <= 1'b0;
            if (adv2) v2_reg <= 1'b1;
            else if (m_ready) v2_reg <= 1'b0;
        end
        if (adv1) begin
            kind_reg <= s_kind;
            neg_reg  <= neg_next;
            mag_reg  <= mag_next;
        end
        if (adv2) res_reg <= res_next;
    end

    assign m_valid       = v2_reg;
    assign m_result_bits = res_reg;

    a_single_upper: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 && kind_reg == KIND_SINGLE |=> res_reg[63:32] == 32'd0)
        else $error("single result has upper bits set");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_bits))
        else $error("result changed under stall");
    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        adv2 && mag_reg == '0 |=> res_reg == '0)
        else $error("zero source not mapped to +0");
    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        v1_reg && v2_reg && !m_ready |-> !s_ready)
        else $error("accepted into full pipe");
endmodule
`default_nettype wire

### bench/tb_int_to_float_convert.sv
// Testbench for int_to_float_convert: signed integer to IEEE 754 conversion.
// Predicts each result with a local round-to-nearest-even converter; uses itf_pkg.
`timescale 1ns / 100ps
module tb_int_to_float_convert;
    import itf_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_kind = KIND_DOUBLE;
    logic        s_source_is_64 = 1'b0;
    logic [63:0] s_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [63:0] m_result_bits;

    word_t       expected_floats[$];
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    int          errors = 0;
    longint      cycles = 0;

    int_to_float_convert dut (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    function automatic word_t convert(logic kind, logic wide, word_t raw);
        word_t v, mag, norm, m, rem, half, e, frac;
        int    lz, sig, ebits, bias, drop;
        logic  neg;
        v = wide ? raw : {{32{raw[31]}}, raw[31:0]};
        neg = v[63];
        mag = neg ? (~v + 64'd1) : v;
        if (mag == 0) return '0;
        sig = (kind == KIND_SINGLE) ? 24 : 53;
        ebits = (kind == KIND_SINGLE) ? 8 : 11;
        bias = (kind == KIND_SINGLE) ? 127 : 1023;
        lz = 0;
        while (!mag[63 - lz]) lz++;
        norm = mag << lz;
        drop = 64 - sig;
        m = norm >> drop;
        rem = norm & ((64'd1 << drop) - 64'd1);
        half = 64'd1 << (drop - 1);
        e = word_t'(bias + 63 - lz);
        if (rem > half || (rem == half && m[0])) m++;
        if (m == (64'd1 << sig)) begin
            m = m >> 1;
            e++;
        end
        frac = m & ((64'd1 << (sig - 1)) - 64'd1);
        return (word_t'(neg) << (sig - 1 + ebits)) | (e << (sig - 1)) | frac;
    endfunction

    // s_valid stays high between back-to-back items; it drops only while idling
    task automatic send_item(logic kind, logic wide, word_t raw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_source_is_64 <= wide;
        s_value <= raw;
        expected_floats.push_back(convert(kind, wide, raw));
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("Verification failed");
            $finish;
        end
        if (aresetn) m_ready <= !hold_off && ($urandom_range(99) >= recv_idle_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_floats.size() == 0) begin
                $display("%0t unexpected result %h", $time, m_result_bits);
                errors++;
            end else begin
                word_t exp_bits;
                exp_bits = expected_floats.pop_front();
                if (m_result_bits !== exp_bits) begin
                    $display("%0t expected %h actual %h", $time, exp_bits, m_result_bits);
                    errors++;
                end
            end
        end
    end

    function automatic word_t random_value();
        word_t v;
        int    sh;
        v = {$urandom, $urandom};
        case ($urandom_range(3))
            0: sh = $urandom_range(63);
            1: sh = 0;
            default: sh = $urandom_range(40, 63);
        endcase
        v = v >> sh;
        if ($urandom_range(1)) v = ~v + 64'd1;
        return v;
    endfunction

    task automatic test_directed();
        word_t vals[12];
        vals = '{64'd0, 64'd1, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                 64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_8000_0000, 64'h1234_5678_7FFF_FFFF,
                 64'h0000_0000_0100_0001, 64'h0000_0000_0100_0003,
                 64'h0020_0000_0000_0001, 64'h0020_0000_0000_0003, 64'h00FF_FFFF_FFFF_FFFF};
        foreach (vals[i]) begin
            send_item(KIND_DOUBLE, 1'b1, vals[i]);
            send_item(KIND_SINGLE, i[0], vals[i]);
        end
    endtask

    task automatic test_random(int count);
        repeat (count) send_item(1'($urandom_range(1)), 1'($urandom_range(1)),
                                 random_value());
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        fork
            begin
                repeat (60) @(posedge aclk);
                hold_off = 1'b0;
            end
            test_random(30);
        join
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        send_idle_pct = 27;
        recv_idle_pct = 69;
        test_random(440);
        send_idle_pct = 69;
        recv_idle_pct = 27;
        test_random(440);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_backpressure();
        test_random(420);
        s_valid <= 1'b0;
        while (expected_floats.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/itf_pkg.sv
rtl/int_to_float_convert.sv
bench/tb_int_to_float_convert.sv
